// File: design/jhms_pkg.sv
// Shared types and constants of the JPEG header marker scanner.
`default_nettype none

package jhms_pkg;

    localparam int DATA_W  = 8;
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 7;
    localparam int SIZE_W  = 8;
    localparam int FRAME_W = 24;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TABLE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

    localparam logic [DATA_W-1:0] MARK_PREFIX = 8'hFF;
    localparam logic [DATA_W-1:0] MARK_DQT    = 8'hDB;
    localparam logic [DATA_W-1:0] MARK_SOF0   = 8'hC0;

    localparam logic [FRAME_W-1:0] MAX_FRAME_RESET = 24'd1048576;
    localparam logic [FRAME_W-1:0] POS_SATURATED   = 24'hFFFFFF;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [DATA_W-1:0]  value;
        logic [INDEX_W-1:0] table_index;
        logic [DATA_W-1:0]  width_blocks;
        logic [DATA_W-1:0]  height_blocks;
        logic               sof_found;
        logic [SIZE_W-1:0]  table_size;
        logic               table_mirrored;
        logic               frame_end;
    } result_t;

endpackage

`default_nettype wire

// File: design/jhms_byte_if.sv
// Input channel carrying one frame byte and its end-of-frame flag per beat.
`default_nettype none

interface jhms_byte_if;
    logic                          valid;
    logic                          ready;
    logic [jhms_pkg::DATA_W-1:0]   data;
    logic                          last;

    modport source (output valid, output data, output last, input ready);
    modport sink (input valid, input data, input last, output ready);
endinterface

`default_nettype wire

// File: design/jhms_result_if.sv
// Output channel carrying one scanner result per beat.
`default_nettype none

interface jhms_result_if;
    logic                          valid;
    logic                          ready;
    logic [jhms_pkg::KIND_W-1:0]   kind;
    logic [jhms_pkg::DATA_W-1:0]   value;
    logic [jhms_pkg::INDEX_W-1:0]  table_index;
    logic [jhms_pkg::DATA_W-1:0]   width_blocks;
    logic [jhms_pkg::DATA_W-1:0]   height_blocks;
    logic                          sof_found;
    logic [jhms_pkg::SIZE_W-1:0]   table_size;
    logic                          table_mirrored;
    logic                          frame_end;

    modport source (output valid, output kind, output value, output table_index,
                    output width_blocks, output height_blocks, output sof_found,
                    output table_size, output table_mirrored, output frame_end,
                    input ready);
    modport sink (input valid, input kind, input value, input table_index,
                  input width_blocks, input height_blocks, input sof_found,
                  input table_size, input table_mirrored, input frame_end,
                  output ready);
endinterface

`default_nettype wire

// File: design/jpeg_header_marker_scanner_core.sv
// Top level of the JPEG header marker scanner: marker parser and result queue.
// Usage:
// Frame bytes enter on byte_in, one per beat, with last set on the final byte.
// The first HEADER_BYTES bytes of a frame are scanned for DQT and SOF0 markers.
// Table bytes leave on result_out as table beats with their table position, and
// at the end of the header (or at an early last byte) one summary beat follows.
// Later bytes leave as payload beats while their frame position is below
// max_frame_bytes, which is written through cfg_wr_en and cfg_wr_data.
// Every accepted byte is parsed in the cycle it is accepted; its results are
// registered into a four-entry result queue that drives result_out.
// A byte gives at most two results; the queue drains one beat per cycle while
// the receiver is ready, and byte_in is ready, taking one byte per cycle,
// whenever the queue has room for two results, which a stalled receiver
// eventually removes. Throughput is one byte per cycle while byte_in is ready.
// Reset empties the queue, clears all scan state and the stored image size, and
// sets max_frame_bytes to 1048576.
`default_nettype none

module jpeg_header_marker_scanner_core #(
    parameter int HEADER_BYTES = 524,
    parameter int TABLE_BYTES  = 128
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [jhms_pkg::FRAME_W-1:0]   cfg_wr_data,
    jhms_byte_if.sink                           byte_in,
    jhms_result_if.source                       result_out
);

    localparam int TW = $clog2(TABLE_BYTES + 1);
    localparam int QDEPTH = 4;
    localparam int QPW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    localparam logic [jhms_pkg::FRAME_W-1:0] HDR_LEN   = jhms_pkg::FRAME_W'(HEADER_BYTES);
    localparam logic [jhms_pkg::FRAME_W-1:0] HDR_LAST  = jhms_pkg::FRAME_W'(HEADER_BYTES - 1);
    localparam logic [jhms_pkg::FRAME_W-1:0] SCAN_LIMIT = jhms_pkg::FRAME_W'(HEADER_BYTES - 8);
    localparam logic [TW-1:0] TABLE_FULL = TW'(TABLE_BYTES);
    localparam logic [TW-1:0] TABLE_HALF = TW'(TABLE_BYTES / 2);

    typedef enum logic [3:0] {
        PH_LOOK,
        PH_FF,
        PH_DQT_HI,
        PH_DQT_LO,
        PH_SKIP,
        PH_SOF_SKIP,
        PH_SOF_H1,
        PH_SOF_H2,
        PH_SOF_W1,
        PH_SOF_W2
    } phase_t;

    function automatic phase_t free_scan(phase_t cur, logic [7:0] b, logic pos_ok);
        phase_t res;
        res = (pos_ok && b == jhms_pkg::MARK_PREFIX) ? PH_FF : PH_LOOK;
        if (cur == PH_FF && b == jhms_pkg::MARK_DQT) begin
            res = PH_DQT_HI;
        end else if (cur == PH_FF && b == jhms_pkg::MARK_SOF0) begin
            res = PH_SOF_SKIP;
        end
        return res;
    endfunction

    logic [jhms_pkg::FRAME_W-1:0] max_frame_reg;
    logic [jhms_pkg::FRAME_W-1:0] pos_reg, pos_next;
    phase_t                       phase_reg, phase_next;
    logic [15:0]                  skip_reg, skip_next;
    logic [7:0]                   hold_reg, hold_next;
    logic [7:0]                   height_tmp_reg, height_tmp_next;
    logic [TW-1:0]                copy_reg, copy_next;
    logic                         wait_reg, wait_next;
    logic [TW-1:0]                tables_reg, tables_next;
    logic                         sof_reg, sof_next;
    logic                         done_reg, done_next;
    logic [7:0]                   height_reg, height_next;
    logic [7:0]                   width_reg, width_next;
    logic [QPW-1:0]               wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]               rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]               count_reg, count_next;

    jhms_pkg::result_t            queue_mem [QDEPTH];
    jhms_pkg::result_t            res0, res1, head;

    logic                         in_fire, out_fire;
    logic                         in_hdr, emit_tbl, emit_sum, emit_pay;
    logic [1:0]                   n_res;
    logic [TW-1:0]                tables_mid, copy_mid;
    logic [TW:0]                  committed;
    logic [TW-1:0]                room, ts_cap;
    logic [15:0]                  seg_len, ts_raw;
    logic [jhms_pkg::FRAME_W:0]   reach;
    logic [jhms_pkg::FRAME_W-1:0] pos_m1;
    logic                         pos_ok, pos_m1_ok, mirror;
    phase_t                       ph_mid;

    assign in_fire  = byte_in.valid && byte_in.ready;
    assign out_fire = result_out.valid && result_out.ready;
    assign byte_in.ready = count_reg <= QCW'(QDEPTH - 2);

    always_comb
    begin
        pos_next        = pos_reg;
        phase_next      = phase_reg;
        skip_next       = skip_reg;
        hold_next       = hold_reg;
        height_tmp_next = height_tmp_reg;
        copy_next       = copy_reg;
        wait_next       = wait_reg;
        tables_next     = tables_reg;
        sof_next        = sof_reg;
        done_next       = done_reg;
        height_next     = height_reg;
        width_next      = width_reg;
        res0            = '0;
        res1            = '0;
        emit_tbl        = 1'b0;
        emit_sum        = 1'b0;
        emit_pay        = 1'b0;
        n_res           = 2'd0;
        mirror          = 1'b0;
        ph_mid          = PH_LOOK;
        in_hdr          = pos_reg < HDR_LEN;
        pos_m1          = pos_reg - 1'b1;
        pos_ok          = pos_reg < SCAN_LIMIT;
        pos_m1_ok       = pos_m1 < SCAN_LIMIT;
        seg_len         = {hold_reg, byte_in.data};
        reach           = {1'b0, pos_m1} + (jhms_pkg::FRAME_W + 1)'(seg_len);
        ts_raw          = (seg_len < 16'd3) ? 16'd0 : seg_len - 16'd3;
        emit_tbl        = in_hdr && !wait_reg && copy_reg != '0;
        tables_mid      = tables_reg + TW'(emit_tbl);
        copy_mid        = copy_reg - TW'(emit_tbl);
        committed       = {1'b0, tables_reg} + {1'b0, copy_reg};
        room            = (committed < {1'b0, TABLE_FULL}) ? TW'(TABLE_FULL - committed[TW-1:0]) : '0;
        ts_cap          = (ts_raw > 16'(room)) ? room : ts_raw[TW-1:0];

        if (in_fire) begin
            if (in_hdr) begin
                tables_next = tables_mid;
                copy_next   = copy_mid;
                wait_next   = 1'b0;
                if (!done_reg) begin
                    case (phase_reg)
                        PH_LOOK, PH_FF:
                        begin
                            phase_next = free_scan(phase_reg, byte_in.data, pos_ok);
                            if (phase_next == PH_SOF_SKIP) begin
                                skip_next = 16'd3;
                            end
                        end
                        PH_DQT_HI:
                        begin
                            hold_next  = byte_in.data;
                            phase_next = PH_DQT_LO;
                        end
                        PH_DQT_LO:
                        begin
                            phase_next = PH_LOOK;
                            ph_mid = free_scan(PH_LOOK, hold_reg, pos_m1_ok);
                            if (reach < (jhms_pkg::FRAME_W + 1)'(HEADER_BYTES)) begin
                                if (ts_cap != '0) begin
                                    copy_next = copy_mid + ts_cap;
                                    wait_next = 1'b1;
                                end
                                if ((committed + {1'b0, ts_cap}) == {1'b0, TABLE_FULL}
                                    && sof_reg) begin
                                    done_next = 1'b1;
                                end else if (seg_len >= 16'd3) begin
                                    skip_next  = ts_raw;
                                    phase_next = (ts_raw != 16'd0) ? PH_SKIP : PH_LOOK;
                                end else begin
                                    phase_next = free_scan(ph_mid, byte_in.data, pos_ok);
                                end
                            end else begin
                                phase_next = free_scan(ph_mid, byte_in.data, pos_ok);
                            end
                            if (phase_next == PH_SOF_SKIP) begin
                                skip_next = 16'd3;
                            end
                        end
                        PH_SKIP, PH_SOF_SKIP:
                        begin
                            skip_next = (skip_reg != 16'd0) ? skip_reg - 16'd1 : 16'd0;
                            if (skip_next == 16'd0) begin
                                phase_next = (phase_reg == PH_SKIP) ? PH_LOOK : PH_SOF_H1;
                            end
                        end
                        PH_SOF_H1:
                        begin
                            hold_next  = byte_in.data;
                            phase_next = PH_SOF_H2;
                        end
                        PH_SOF_H2:
                        begin
                            height_tmp_next = {hold_reg[2:0], byte_in.data[7:3]};
                            phase_next      = PH_SOF_W1;
                        end
                        PH_SOF_W1:
                        begin
                            hold_next  = byte_in.data;
                            phase_next = PH_SOF_W2;
                        end
                        PH_SOF_W2:
                        begin
                            height_next = height_tmp_reg;
                            width_next  = {hold_reg[2:0], byte_in.data[7:3]};
                            sof_next    = 1'b1;
                            if (committed == {1'b0, TABLE_FULL}) begin
                                done_next = 1'b1;
                            end
                            phase_next = PH_LOOK;
                        end
                        default:
                        begin
                            phase_next = PH_LOOK;
                        end
                    endcase
                end
                emit_sum = (pos_reg == HDR_LAST) || byte_in.last;
            end else begin
                emit_pay = pos_reg < max_frame_reg;
            end

            mirror = tables_mid == TABLE_HALF;
            if (emit_tbl) begin
                res0.kind        = jhms_pkg::KIND_TABLE;
                res0.value       = byte_in.data;
                res0.table_index = tables_reg[jhms_pkg::INDEX_W-1:0];
            end else if (emit_pay) begin
                res0.kind  = jhms_pkg::KIND_PAYLOAD;
                res0.value = byte_in.data;
            end
            if (emit_sum) begin
                res1.kind           = jhms_pkg::KIND_SUMMARY;
                res1.width_blocks   = width_next;
                res1.height_blocks  = height_next;
                res1.sof_found      = sof_next;
                res1.table_size     = mirror ? jhms_pkg::SIZE_W'(TABLE_BYTES)
                                             : jhms_pkg::SIZE_W'(tables_mid);
                res1.table_mirrored = mirror;
                res1.frame_end      = byte_in.last;
                if (!emit_tbl) begin
                    res0 = res1;
                end
            end else begin
                res0.frame_end = byte_in.last;
            end
            n_res = 2'(emit_tbl) + 2'(emit_pay) + 2'(emit_sum);

            if (byte_in.last) begin
                pos_next        = '0;
                phase_next      = PH_LOOK;
                skip_next       = '0;
                hold_next       = '0;
                height_tmp_next = '0;
                copy_next       = '0;
                wait_next       = 1'b0;
                tables_next     = '0;
                sof_next        = 1'b0;
                done_next       = 1'b0;
            end else if (pos_reg != jhms_pkg::POS_SATURATED) begin
                pos_next = pos_reg + 1'b1;
            end
        end

        wr_ptr_next = wr_ptr_reg + QPW'(n_res);
        rd_ptr_next = rd_ptr_reg + QPW'(out_fire);
        count_next  = count_reg + QCW'(n_res) - QCW'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_frame_reg  <= jhms_pkg::MAX_FRAME_RESET;
            pos_reg        <= '0;
            phase_reg      <= PH_LOOK;
            skip_reg       <= '0;
            hold_reg       <= '0;
            height_tmp_reg <= '0;
            copy_reg       <= '0;
            wait_reg       <= 1'b0;
            tables_reg     <= '0;
            sof_reg        <= 1'b0;
            done_reg       <= 1'b0;
            height_reg     <= '0;
            width_reg      <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                max_frame_reg <= cfg_wr_data;
            end
            pos_reg        <= pos_next;
            phase_reg      <= phase_next;
            skip_reg       <= skip_next;
            hold_reg       <= hold_next;
            height_tmp_reg <= height_tmp_next;
            copy_reg       <= copy_next;
            wait_reg       <= wait_next;
            tables_reg     <= tables_next;
            sof_reg        <= sof_next;
            done_reg       <= done_next;
            height_reg     <= height_next;
            width_reg      <= width_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_res != 2'd0) begin
            queue_mem[wr_ptr_reg] <= res0;
        end
        if (n_res == 2'd2) begin
            queue_mem[wr_ptr_reg + 1'b1] <= res1;
        end
    end

    assign head = queue_mem[rd_ptr_reg];

    assign result_out.valid          = count_reg != '0;
    assign result_out.kind           = head.kind;
    assign result_out.value          = head.value;
    assign result_out.table_index    = head.table_index;
    assign result_out.width_blocks   = head.width_blocks;
    assign result_out.height_blocks  = head.height_blocks;
    assign result_out.sof_found      = head.sof_found;
    assign result_out.table_size     = head.table_size;
    assign result_out.table_mirrored = head.table_mirrored;
    assign result_out.frame_end      = head.frame_end;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCW'(QDEPTH))
        else $error("Result queue count exceeds its depth.");

    a_table_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, tables_reg} + {1'b0, copy_reg}) <= {1'b0, TABLE_FULL})
        else $error("Collected and pending table bytes exceed the table size.");

    a_wait_has_copy: assert property (@(posedge clk) disable iff (!rst_n)
        wait_reg |-> copy_reg != '0)
        else $error("Copy wait is set with no table bytes pending.");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && byte_in.last) |=> (pos_reg == '0 && tables_reg == '0 && !sof_reg))
        else $error("Frame state was not cleared after the last byte.");

endmodule

`default_nettype wire
